[src/hsha_pkg.sv]
// ----------------------------------------------------------------------------
// hsha_pkg
// Shared types, constants and SHA-256 helper functions for the HMAC engine.
// ----------------------------------------------------------------------------
package hsha_pkg;

  localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd4;
  localparam logic [2:0] REG_MAC_LENGTH = 3'd5;

  localparam logic [5:0] KEY_MAX     = 6'd32;
  localparam logic [5:0] MAC_RESET   = 6'd32;
  localparam logic [7:0] IPAD_BYTE   = 8'h36;
  localparam logic [7:0] OPAD_BYTE   = 8'h5c;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;
  // opad block plus 32-byte inner digest
  localparam logic [31:0] OUTER_BITS = 32'd768;

  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0]  hash_t;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_byte;
    logic       no_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        word_last;
  } result_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [5:0]       key_len;
    logic [5:0]       mac_len;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic use_iv;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_const(logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[src/hmac_sha256_engine_core.sv]
// ----------------------------------------------------------------------------
// hmac_sha256_engine_core
// HMAC-SHA256 over a byte stream, key and MAC length from registers.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  message   push / full            item_t: message_byte, last_byte, no_byte
//  result    pop / empty            result_t: digest_word, word_index, word_last
//  config    cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (64 bits)
//
// An ordinary byte is taken in S_IDLE and stored in S_PROC; every 64th byte adds a
// block compression (load, 64 rounds one a cycle, add, done), and the first beat of
// a message adds the ipad block, whose load shares the cycle that takes the beat.
// The final beat runs 3 or 4 compressions before the MAC words, which leave one a
// cycle while the result queue has room. Synchronous reset; cfg_ready is always
// high. A two-deep input queue and a four-deep result queue decouple both sides.
module hmac_sha256_engine_core import hsha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       message,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t      cfg;
  logic      item_valid;
  item_t     item;
  logic      item_take;
  cmp_ctrl_t cmp_ctrl;
  cmp_stat_t cmp_stat;
  block_t    cmp_block;
  hash_t     hash_out;
  logic      res_push;
  result_t   res;
  logic      res_full;

  result_t    out_mem [4];
  logic [1:0] out_wr;
  logic [1:0] out_rd;
  logic [2:0] out_cnt;
  logic       out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key     <= '0;
      cfg.key_len <= 6'd0;
      cfg.mac_len <= MAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_WORD_0: cfg.key[0] <= cfg_data;
        REG_KEY_WORD_1: cfg.key[1] <= cfg_data;
        REG_KEY_WORD_2: cfg.key[2] <= cfg_data;
        REG_KEY_WORD_3: cfg.key[3] <= cfg_data;
        REG_KEY_LENGTH: cfg.key_len <= cfg_data[5:0];
        REG_MAC_LENGTH: cfg.mac_len <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  hsha_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .message    (message),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  hsha_compress u_compress (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cmp_ctrl),
    .block    (cmp_block),
    .stat     (cmp_stat),
    .hash_out (hash_out)
  );

  hsha_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cmp_ctrl   (cmp_ctrl),
    .cmp_block  (cmp_block),
    .cmp_stat   (cmp_stat),
    .hash_out   (hash_out),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  // result queue
  assign res_full = (out_cnt == 3'd4);
  assign empty    = (out_cnt == 3'd0);
  assign out_take = pop && !empty;
  assign result   = out_mem[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr  <= 2'd0;
      out_rd  <= 2'd0;
      out_cnt <= 3'd0;
    end else begin
      if (res_push) out_wr <= out_wr + 2'd1;
      if (out_take) out_rd <= out_rd + 2'd1;
      out_cnt <= out_cnt + {2'd0, res_push} - {2'd0, out_take};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_mem[out_wr] <= res;
  end

`ifndef NO_ASSERTIONS
  a_out_bound: assert property (@(posedge clk) disable iff (rst) out_cnt <= 3'd4)
    else $error("result queue count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result beat pushed into full queue");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmp_ctrl.start |-> !cmp_stat.busy)
    else $error("compression started while busy");
`endif

endmodule

[src/hsha_front.sv]
// ----------------------------------------------------------------------------
// hsha_front
// Input side: takes message beats, drops empty non-final beats, two-deep queue.
// ----------------------------------------------------------------------------
module hsha_front import hsha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t message,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       store;
  logic       take;

  assign full       = (count == 2'd2);
  assign store      = push && !full && !(message.no_byte && !message.last_byte);
  assign item_valid = (count != 2'd0);
  assign take       = item_take && item_valid;
  assign item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (store) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, store} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (store) mem[wr_ptr] <= message;
  end

endmodule

[src/hsha_compress.sv]
// ----------------------------------------------------------------------------
// hsha_compress
// SHA-256 compression, one round a cycle, holds the chaining value.
// ----------------------------------------------------------------------------
module hsha_compress import hsha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmp_ctrl_t ctrl,
  input  block_t    block,
  output cmp_stat_t stat,
  output hash_t     hash_out
);

  block_t     w;
  block_t     w_next;
  hash_t      v;
  hash_t      v_next;
  hash_t      h;
  logic [5:0] round;
  logic       busy;
  logic       fin;
  logic       done;

  logic [31:0] t1, t2, s0, s1, w_new;

  always_comb begin
    t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(round) + w[0];
    t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    v_next    = v;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
    // schedule: w[0] is W[t], the window slides by one each round
    s0    = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1    = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    for (int i = 0; i < 15; i++) w_next[i] = w[i + 1];
    w_next[15] = w_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (round == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      w     <= block;
      v     <= ctrl.use_iv ? INIT_HASH : h;
      h     <= ctrl.use_iv ? INIT_HASH : h;
      round <= 6'd0;
    end else if (busy) begin
      w     <= w_next;
      v     <= v_next;
      round <= round + 6'd1;
    end else if (fin) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end

  assign stat.busy = busy || fin;
  assign stat.done = done;
  assign hash_out  = h;

endmodule

[src/hsha_back.sv]
// ----------------------------------------------------------------------------
// hsha_back
// Sequencer: block buffer, padding, inner/outer hash passes, MAC word output.
// ----------------------------------------------------------------------------
module hsha_back import hsha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  item_t     item,
  output logic      item_take,
  output cmp_ctrl_t cmp_ctrl,
  output block_t    cmp_block,
  input  cmp_stat_t cmp_stat,
  input  hash_t     hash_out,
  output logic      res_push,
  output result_t   res,
  input  logic      res_full
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_IPADW = 14'b00000000000010,
    S_PROC  = 14'b00000000000100,
    S_BLKL  = 14'b00000000001000,
    S_BLKW  = 14'b00000000010000,
    S_FIN   = 14'b00000000100000,
    S_PAD1W = 14'b00000001000000,
    S_PADL  = 14'b00000010000000,
    S_PAD2W = 14'b00000100000000,
    S_OPADL = 14'b00001000000000,
    S_OPADW = 14'b00010000000000,
    S_OUTL  = 14'b00100000000000,
    S_OUTW  = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t      state;
  state_t      state_next;
  item_t       cur;
  logic        started;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [63:0] total;
  logic [63:0] total_c;
  block_t      buffer;
  hash_t       inner;
  logic [1:0]  k;

  logic [5:0]  klen;
  logic [5:0]  mlen;
  logic [1:0]  words_m1;
  logic [255:0] key_flat;
  block_t      ipad_blk, opad_blk, pad_blk, len_blk, outer_blk;
  logic [63:0] word_raw;

  assign klen     = (cfg.key_len > KEY_MAX) ? KEY_MAX : cfg.key_len;
  assign mlen     = (cfg.mac_len > KEY_MAX) ? KEY_MAX : cfg.mac_len;
  assign words_m1 = (mlen == 6'd0) ? 2'd0 : 2'((mlen - 6'd1) >> 3);
  assign key_flat = {cfg.key[0], cfg.key[1], cfg.key[2], cfg.key[3]};
  assign total_c  = bit_count + {55'd0, fill, 3'd0};

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(4 * j + b) < klen) begin
          ipad_blk[j][8 * (3 - b) +: 8] = key_flat[255 - 8 * (4 * j + b) -: 8] ^ IPAD_BYTE;
          opad_blk[j][8 * (3 - b) +: 8] = key_flat[255 - 8 * (4 * j + b) -: 8] ^ OPAD_BYTE;
        end else begin
          ipad_blk[j][8 * (3 - b) +: 8] = IPAD_BYTE;
          opad_blk[j][8 * (3 - b) +: 8] = OPAD_BYTE;
        end
        if (6'(4 * j + b) < fill) pad_blk[j][8 * (3 - b) +: 8] = buffer[j][8 * (3 - b) +: 8];
        else if (6'(4 * j + b) == fill) pad_blk[j][8 * (3 - b) +: 8] = PAD_MARK;
        else pad_blk[j][8 * (3 - b) +: 8] = 8'h00;
      end
    end
    // length fits in this block only when the mark leaves eight bytes free
    if (fill < 6'd56) begin
      pad_blk[14] = total_c[63:32];
      pad_blk[15] = total_c[31:0];
    end
    len_blk     = '0;
    len_blk[14] = total[63:32];
    len_blk[15] = total[31:0];
    outer_blk   = '0;
    for (int j = 0; j < 8; j++) outer_blk[j] = inner[j];
    outer_blk[8]  = {PAD_MARK, 24'd0};
    outer_blk[15] = OUTER_BITS;
  end

  always_comb begin
    cmp_ctrl   = '0;
    cmp_block  = buffer;
    item_take  = 1'b0;
    res_push   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmp_block = ipad_blk;
        if (item_valid) begin
          item_take = 1'b1;
          if (!started) begin
            cmp_ctrl   = '{start: 1'b1, use_iv: 1'b1};
            state_next = S_IPADW;
          end else begin
            state_next = S_PROC;
          end
        end
      end
      S_IPADW: if (cmp_stat.done) state_next = S_PROC;
      S_PROC: begin
        if (cur.no_byte) state_next = S_FIN;
        else if (fill == 6'd63) state_next = S_BLKL;
        else if (cur.last_byte) state_next = S_FIN;
        else state_next = S_IDLE;
      end
      S_BLKL: begin
        cmp_ctrl   = '{start: 1'b1, use_iv: 1'b0};
        state_next = S_BLKW;
      end
      S_BLKW: if (cmp_stat.done) state_next = cur.last_byte ? S_FIN : S_IDLE;
      S_FIN: begin
        cmp_block  = pad_blk;
        cmp_ctrl   = '{start: 1'b1, use_iv: 1'b0};
        state_next = (fill >= 6'd56) ? S_PAD1W : S_PAD2W;
      end
      S_PAD1W: if (cmp_stat.done) state_next = S_PADL;
      S_PADL: begin
        cmp_block  = len_blk;
        cmp_ctrl   = '{start: 1'b1, use_iv: 1'b0};
        state_next = S_PAD2W;
      end
      S_PAD2W: if (cmp_stat.done) state_next = S_OPADL;
      S_OPADL: begin
        cmp_block  = opad_blk;
        cmp_ctrl   = '{start: 1'b1, use_iv: 1'b1};
        state_next = S_OPADW;
      end
      S_OPADW: if (cmp_stat.done) state_next = S_OUTL;
      S_OUTL: begin
        cmp_block  = outer_blk;
        cmp_ctrl   = '{start: 1'b1, use_iv: 1'b0};
        state_next = S_OUTW;
      end
      S_OUTW: if (cmp_stat.done) state_next = S_EMIT;
      S_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (k == words_m1) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    word_raw = {hash_out[{k, 1'b0}], hash_out[{k, 1'b1}]};
    for (int b = 0; b < 8; b++) begin
      if ({1'b0, k, 3'(b)} >= mlen) word_raw[8 * (7 - b) +: 8] = 8'h00;
    end
    res.digest_word = word_raw;
    res.word_index  = k;
    res.word_last   = (k == words_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      fill      <= 6'd0;
      bit_count <= 64'd0;
      k         <= 2'd0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IPADW: begin
          if (cmp_stat.done) begin
            started   <= 1'b1;
            bit_count <= BLOCK_BITS;
            fill      <= 6'd0;
          end
        end
        S_PROC: if (!cur.no_byte) fill <= fill + 6'd1;
        S_BLKW: if (cmp_stat.done) bit_count <= bit_count + BLOCK_BITS;
        S_OUTW: if (cmp_stat.done) k <= 2'd0;
        S_EMIT: begin
          if (!res_full) begin
            k <= k + 2'd1;
            if (k == words_m1) begin
              started   <= 1'b0;
              fill      <= 6'd0;
              bit_count <= 64'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) cur <= item;
    if (state == S_PROC && !cur.no_byte)
      buffer[fill[5:2]][{~fill[1:0], 3'd0} +: 8] <= cur.message_byte;
    if (state == S_FIN) total <= total_c;
    if (state == S_PAD2W && cmp_stat.done) inner <= hash_out;
  end

endmodule
